// ===== src/dtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and fixed constants shared by the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TIME_W   = 32;
  localparam int ID_W     = 32;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 3;
  localparam int CFG_W    = 16;
  localparam int FIRES_W  = 5;

  localparam logic [FIRES_W-1:0] FIRES_RESET = 5'd5;
  localparam logic [FIRES_W-1:0] FIRES_MIN   = 5'd1;
  localparam logic [FIRES_W-1:0] FIRES_MAX   = 5'd16;

  typedef enum logic [1:0] {
    OP_SCHED_ABS = 2'd0,
    OP_SCHED_REL = 2'd1,
    OP_CANCEL    = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED  = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_FIRED  = 3'd3,
    KIND_IDLE   = 3'd4
  } kind_t;

  typedef enum logic {
    REG_MAX_FIRES = 1'b0,
    REG_MIN_DELAY = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_SUM,
    ST_SCH_FIX,
    ST_INS_START,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_CAN_START,
    ST_CAN_SCAN,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== src/dtq_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Pending tasks kept sorted by deadline in a ring-buffered memory; schedule,
// cancel and tick run under a small sequencer with one shared adder and one
// shared magnitude comparator.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in_      in_valid/in_ready  op, current_time, time_value, task_handle,
//                              cancel_id
//  out_     out_valid/out_ready kind, task_id, fired_handle, found, last
//  cfg_     cfg_we (no wait)   cfg_index, cfg_wdata
//
//  Schedule: sum, fix, then a scan from the tail moving later entries up;
//  a full store is answered from the sum step. Cancel: search and shift in
//  one pass over the stored entries. Tick: checks the head entry per fired
//  task until the fire limit, an empty store or a task not yet due stops it.
//  One item at a time; in_ready is low until its last result is registered.
//  A stalled out_ready holds the sequencer only where a result must be
//  emitted. Synchronous active-low reset; store contents need no clearing.
// ----------------------------------------------------------------------------
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_op,
  input  wire logic [TIME_W-1:0]   in_current_time,
  input  wire logic [TIME_W-1:0]   in_time_value,
  input  wire logic [HANDLE_W-1:0] in_task_handle,
  input  wire logic [ID_W-1:0]     in_cancel_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic [ID_W-1:0]          out_task_id,
  output logic [HANDLE_W-1:0]      out_fired_handle,
  output logic                     out_found,
  output logic                     out_last,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int ENT_W = TIME_W + ID_W + HW;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // logical position -> memory address, relative to the ring head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] lpos);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(lpos);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_W-1:0]     next_id_r, next_id_nxt;
  logic                hold_v_r, hold_v_nxt;
  logic [FIRES_W-1:0]  max_fires_r, max_fires_nxt;
  logic [CFG_W-1:0]    min_delay_r, min_delay_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]    lidx_r, lidx_nxt;
  logic [FIRES_W-1:0]  fires_r, fires_nxt;
  logic                found_r, found_nxt;
  logic [TIME_W-1:0]   when_r, when_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   tv_r, tv_nxt;
  logic [HW-1:0]       handle_r, handle_nxt;
  logic [ID_W-1:0]     cid_r, cid_nxt;
  kind_t               res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [HW-1:0]       res_handle_r, res_handle_nxt;
  logic                res_found_r, res_found_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_last_r, out_last_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0]    mem_wdata, mem_rdata;
  logic [TIME_W-1:0]   rd_deadline;
  logic [ID_W-1:0]     rd_id;
  logic [HW-1:0]       rd_handle;
  logic [ENT_W-1:0]    new_entry;

  logic [TIME_W-1:0]   alu_a, alu_b, alu_sum;
  logic [TIME_W-1:0]   cmp_a, cmp_b;
  logic                cmp_gt;
  logic [FIRES_W-1:0]  fire_limit;
  logic                out_free;
  logic                emit, emit_last;
  kind_t               emit_kind;
  logic [ID_W-1:0]     emit_id;
  logic [HW-1:0]       emit_handle;
  logic                emit_found;
  logic                hit;

  dtq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_deadline = mem_rdata[ENT_W-1 -: TIME_W];
  assign rd_id       = mem_rdata[HW +: ID_W];
  assign rd_handle   = mem_rdata[HW-1:0];
  assign new_entry   = {when_r, next_id_r, handle_r};

  // shared adder and comparator
  assign alu_sum = alu_a + alu_b;
  assign cmp_gt  = cmp_a > cmp_b;

  assign hit      = (rd_id == cid_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (max_fires_r < FIRES_MIN) begin
      fire_limit = FIRES_MIN;
    end else if (max_fires_r > FIRES_MAX) begin
      fire_limit = FIRES_MAX;
    end else begin
      fire_limit = max_fires_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    next_id_nxt    = next_id_r;
    hold_v_nxt     = hold_v_r;
    max_fires_nxt  = max_fires_r;
    min_delay_nxt  = min_delay_r;
    lidx_nxt       = lidx_r;
    fires_nxt      = fires_r;
    found_nxt      = found_r;
    when_nxt       = when_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    tv_nxt         = tv_r;
    handle_nxt     = handle_r;
    cid_nxt        = cid_r;
    res_kind_nxt   = res_kind_r;
    res_id_nxt     = res_id_r;
    res_handle_nxt = res_handle_r;
    res_found_nxt  = res_found_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_entry;
    mem_raddr = phys(head_r, '0);
    alu_a     = tv_r;
    alu_b     = '0;
    cmp_a     = when_r;
    cmp_b     = now_r;

    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_kind   = res_kind_r;
    emit_id     = res_id_r;
    emit_handle = res_handle_r;
    emit_found  = res_found_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_FIRES: max_fires_nxt = cfg_wdata[FIRES_W-1:0];
        REG_MIN_DELAY: min_delay_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          now_nxt    = in_current_time;
          tv_nxt     = in_time_value;
          handle_nxt = in_task_handle[HW-1:0];
          cid_nxt    = in_cancel_id;
          fires_nxt  = '0;
          found_nxt  = 1'b0;
          hold_v_nxt = 1'b0;
          case (op_t'(in_op))
            OP_SCHED_ABS, OP_SCHED_REL: state_nxt = ST_SCH_SUM;
            OP_CANCEL:                  state_nxt = ST_CAN_START;
            default:                    state_nxt = ST_TICK_RD;
          endcase
        end
      end

      ST_SCH_SUM: begin
        alu_a = tv_r;
        alu_b = (op_t'(op_r) == OP_SCHED_REL) ? now_r : '0;
        if (count_r == FULL_CNT) begin
          res_kind_nxt   = KIND_FULL;
          res_id_nxt     = '0;
          res_handle_nxt = '0;
          res_found_nxt  = 1'b0;
          state_nxt      = ST_RESP;
        end else begin
          when_nxt  = alu_sum;
          state_nxt = ST_SCH_FIX;
        end
      end

      ST_SCH_FIX: begin
        // deadline not after now: use now + min_delay
        alu_a = now_r;
        alu_b = TIME_W'(min_delay_r);
        cmp_a = when_r;
        cmp_b = now_r;
        if (!cmp_gt) begin
          when_nxt = alu_sum;
        end
        state_nxt = ST_INS_START;
      end

      ST_INS_START: begin
        lidx_nxt  = count_r;
        mem_raddr = phys(head_r, count_r - 1'b1);
        if (count_r == '0) begin
          state_nxt = ST_INS_PUT;
        end else begin
          state_nxt = ST_INS_SCAN;
        end
      end

      ST_INS_SCAN: begin
        // rdata holds entry lidx_r-1; read of lidx_r-2 issued alongside
        cmp_a     = rd_deadline;
        cmp_b     = when_r;
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, lidx_r);
        mem_raddr = phys(head_r, lidx_r - CNT_W'(2));
        if (cmp_gt) begin
          mem_wdata = mem_rdata;
          lidx_nxt  = lidx_r - 1'b1;
          if (lidx_r == CNT_W'(1)) begin
            state_nxt = ST_INS_PUT;
          end
        end else begin
          mem_wdata      = new_entry;
          count_nxt      = count_r + 1'b1;
          next_id_nxt    = next_id_r + 1'b1;
          res_kind_nxt   = KIND_SCHED;
          res_id_nxt     = next_id_r;
          res_handle_nxt = '0;
          res_found_nxt  = 1'b0;
          state_nxt      = ST_RESP;
        end
      end

      ST_INS_PUT: begin
        mem_we         = 1'b1;
        mem_waddr      = phys(head_r, lidx_r);
        mem_wdata      = new_entry;
        count_nxt      = count_r + 1'b1;
        next_id_nxt    = next_id_r + 1'b1;
        res_kind_nxt   = KIND_SCHED;
        res_id_nxt     = next_id_r;
        res_handle_nxt = '0;
        res_found_nxt  = 1'b0;
        state_nxt      = ST_RESP;
      end

      ST_CAN_START: begin
        lidx_nxt       = '0;
        mem_raddr      = phys(head_r, '0);
        res_kind_nxt   = KIND_CANCEL;
        res_id_nxt     = cid_r;
        res_handle_nxt = '0;
        res_found_nxt  = 1'b0;
        if (count_r == '0) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_CAN_SCAN;
        end
      end

      ST_CAN_SCAN: begin
        // search, and once found move each later entry down by one
        mem_raddr = phys(head_r, lidx_r + 1'b1);
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, lidx_r - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (lidx_r == count_r - 1'b1) begin
          if (found_r || hit) begin
            count_nxt     = count_r - 1'b1;
            res_found_nxt = 1'b1;
          end
          state_nxt = ST_RESP;
        end else begin
          lidx_nxt  = lidx_r + 1'b1;
          found_nxt = found_r || hit;
        end
      end

      ST_TICK_RD: begin
        mem_raddr = phys(head_r, '0);
        if (count_r == '0 || fires_r == fire_limit) begin
          if (hold_v_r) begin
            res_kind_nxt = KIND_FIRED;
          end else begin
            res_kind_nxt   = KIND_IDLE;
            res_id_nxt     = '0;
            res_handle_nxt = '0;
          end
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end else begin
          state_nxt = ST_TICK_CHK;
        end
      end

      ST_TICK_CHK: begin
        mem_raddr = phys(head_r, '0);
        cmp_a     = now_r;
        cmp_b     = rd_deadline;
        if (cmp_gt) begin
          if (!hold_v_r || out_free) begin
            // previous fired item goes out, not last
            emit        = hold_v_r;
            emit_last   = 1'b0;
            emit_kind   = KIND_FIRED;
            emit_found  = 1'b0;
            hold_v_nxt     = 1'b1;
            res_id_nxt     = rd_id;
            res_handle_nxt = rd_handle;
            head_nxt  = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            fires_nxt = fires_r + 1'b1;
            state_nxt = ST_TICK_RD;
          end
        end else begin
          if (hold_v_r) begin
            res_kind_nxt = KIND_FIRED;
          end else begin
            res_kind_nxt   = KIND_IDLE;
            res_id_nxt     = '0;
            res_handle_nxt = '0;
          end
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_kind_nxt   = emit ? emit_kind : out_kind_r;
    out_id_nxt     = emit ? emit_id : out_id_r;
    out_handle_nxt = emit ? HANDLE_W'(emit_handle) : out_handle_r;
    out_found_nxt  = emit ? emit_found : out_found_r;
    out_last_nxt   = emit ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      next_id_r   <= '0;
      hold_v_r    <= 1'b0;
      max_fires_r <= FIRES_RESET;
      min_delay_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      hold_v_r    <= hold_v_nxt;
      max_fires_r <= max_fires_nxt;
      min_delay_r <= min_delay_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lidx_r       <= lidx_nxt;
    fires_r      <= fires_nxt;
    found_r      <= found_nxt;
    when_r       <= when_nxt;
    op_r         <= op_nxt;
    now_r        <= now_nxt;
    tv_r         <= tv_nxt;
    handle_r     <= handle_nxt;
    cid_r        <= cid_nxt;
    res_kind_r   <= res_kind_nxt;
    res_id_r     <= res_id_nxt;
    res_handle_r <= res_handle_nxt;
    res_found_r  <= res_found_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_handle_r <= out_handle_nxt;
    out_found_r  <= out_found_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_task_id      = out_id_r;
  assign out_fired_handle = out_handle_r;
  assign out_found        = out_found_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire
